FILE: hdl/pcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG chunk deframer package
// Shared types and constants for the front parser, the op queue and the
// back end of the deframer.
// ----------------------------------------------------------------------------
package pcd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] SIG_BYTES [8] = '{
        8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
    };

    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    typedef enum logic [2:0] {
        K_NONE   = 3'd0,
        K_DATA   = 3'd1,
        K_WIDTH  = 3'd2,
        K_HEIGHT = 3'd3,
        K_DEPTH  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_RUN   = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       begin_mark;
        logic       last_mark;
        logic       hdr_ready;
        t_status    status;
    } t_op;

endpackage

FILE: hdl/png_chunk_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG chunk deframer
// Byte-serial PNG deframer: signature check, chunk framing, IHDR capture and
// IDAT payload extraction for a downstream inflater.
//
// Usage:
//   The input channel (i_valid / o_stall) takes one file byte per beat, with
//   i_restart high on the first byte of a new file. Every accepted beat
//   yields exactly one result beat on the output channel (o_valid /
//   i_stall): o_out_valid marks IDAT payload bytes, o_stream_begin and
//   o_stream_last mark the first and last payload byte of each IDAT chunk,
//   o_header_ready marks the last IHDR byte, and the image fields and
//   o_status are valid on every beat.
//   Throughput is one byte per clock while the receiver does not stall.
//   An accepted byte becomes an op in the op queue via the front parser,
//   and the back end moves it into the output register as a result beat.
//   When the receiver stalls, the output register holds its beat and the op
//   queue (QUEUE_DEPTH entries) keeps absorbing bytes; o_stall rises only
//   once the queue is full.
//   Reset empties the queue and output register, returns the parser to the
//   signature check and clears the image width, height and bit depth.
// ----------------------------------------------------------------------------
module png_chunk_deframer #(
    parameter int QUEUE_DEPTH = pcd_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_out_valid,
    output logic        o_stream_begin,
    output logic        o_stream_last,
    output logic        o_header_ready,
    output logic [31:0] o_image_width,
    output logic [31:0] o_image_height,
    output logic [7:0]  o_bit_depth,
    output logic [1:0]  o_status
);

    logic         push;
    logic         q_full;
    logic         q_valid;
    logic         pop;
    pcd_pkg::t_op push_op;
    pcd_pkg::t_op pop_op;

    pcd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_in_byte (i_in_byte),
        .i_restart (i_restart),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_op      (push_op)
    );

    pcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (pop_op),
        .i_pop   (pop)
    );

    pcd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_op         (pop_op),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_out_valid    (o_out_valid),
        .o_stream_begin (o_stream_begin),
        .o_stream_last  (o_stream_last),
        .o_header_ready (o_header_ready),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_bit_depth    (o_bit_depth),
        .o_status       (o_status)
    );

endmodule

FILE: hdl/pcd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG chunk deframer front end
// Accepts file bytes, tracks signature and chunk framing, and turns each
// beat into one op for the back end.
// ----------------------------------------------------------------------------
module pcd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_in_byte,
    input  logic          i_restart,
    input  logic          i_q_full,
    output logic          o_push,
    output pcd_pkg::t_op  o_op
);

    typedef enum logic [8:0] {
        PH_SIG      = 9'b0_0000_0001,
        PH_HDR      = 9'b0_0000_0010,
        PH_IHDR     = 9'b0_0000_0100,
        PH_SKIP     = 9'b0_0000_1000,
        PH_IDAT     = 9'b0_0001_0000,
        PH_CRC_NEXT = 9'b0_0010_0000,
        PH_CRC_END  = 9'b0_0100_0000,
        PH_DONE     = 9'b0_1000_0000,
        PH_ERROR    = 9'b1_0000_0000
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [31:0] r_count,  n_count;
    logic [31:0] r_length, n_length;
    logic [31:0] r_type,   n_type;
    logic        r_sig_ok, n_sig_ok;

    t_phase      eff_phase;
    logic [31:0] eff_count;
    logic        eff_sig_ok;
    logic [32:0] count_inc;
    logic [31:0] new_type;
    logic        sig_next;
    pcd_pkg::t_op op;

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign o_op    = op;

    always_comb begin
        eff_phase  = i_restart ? PH_SIG : r_phase;
        eff_count  = i_restart ? 32'd0 : r_count;
        eff_sig_ok = i_restart ? 1'b1 : r_sig_ok;
        count_inc  = {1'b0, eff_count} + 33'd1;
        new_type   = {r_type[23:0], i_in_byte};
        sig_next   = eff_sig_ok && (i_in_byte == pcd_pkg::SIG_BYTES[eff_count[2:0]]);

        n_phase  = eff_phase;
        n_count  = eff_count;
        n_length = r_length;
        n_type   = r_type;
        n_sig_ok = eff_sig_ok;

        op            = '0;
        op.kind       = pcd_pkg::K_NONE;
        op.data       = i_in_byte;

        case (eff_phase)
            PH_SIG: begin
                n_sig_ok = sig_next;
                n_count  = count_inc[31:0];
                if (eff_count[2:0] == 3'd7) begin
                    n_phase = sig_next ? PH_HDR : PH_ERROR;
                    n_count = 32'd0;
                end
            end
            PH_HDR: begin
                if (!eff_count[2]) begin
                    n_length = {r_length[23:0], i_in_byte};
                end else begin
                    n_type = new_type;
                end
                n_count = count_inc[31:0];
                if (eff_count[2:0] == 3'd7) begin
                    n_count = 32'd0;
                    if (new_type == pcd_pkg::TYPE_IHDR) begin
                        n_phase = PH_IHDR;
                    end else if (new_type == pcd_pkg::TYPE_IDAT) begin
                        n_phase = (r_length != 32'd0) ? PH_IDAT : PH_CRC_NEXT;
                    end else if (new_type == pcd_pkg::TYPE_IEND) begin
                        n_phase = PH_CRC_END;
                    end else begin
                        n_phase = (r_length != 32'd0) ? PH_SKIP : PH_CRC_NEXT;
                    end
                end
            end
            PH_IHDR: begin
                if (eff_count[3:0] < 4'd4) begin
                    op.kind = pcd_pkg::K_WIDTH;
                end else if (eff_count[3:0] < 4'd8) begin
                    op.kind = pcd_pkg::K_HEIGHT;
                end else if (eff_count[3:0] == 4'd8) begin
                    op.kind = pcd_pkg::K_DEPTH;
                end
                n_count = count_inc[31:0];
                if (eff_count[3:0] == 4'd12) begin
                    op.hdr_ready = 1'b1;
                    n_phase      = PH_CRC_NEXT;
                    n_count      = 32'd0;
                end
            end
            PH_SKIP: begin
                n_count = count_inc[31:0];
                if (count_inc >= {1'b0, r_length}) begin
                    n_phase = PH_CRC_NEXT;
                    n_count = 32'd0;
                end
            end
            PH_IDAT: begin
                op.kind       = pcd_pkg::K_DATA;
                op.begin_mark = (eff_count == 32'd0);
                n_count       = count_inc[31:0];
                if (count_inc >= {1'b0, r_length}) begin
                    op.last_mark = 1'b1;
                    n_phase      = PH_CRC_NEXT;
                    n_count      = 32'd0;
                end
            end
            PH_CRC_NEXT: begin
                n_count = count_inc[31:0];
                if (eff_count[1:0] == 2'd3) begin
                    n_phase  = PH_HDR;
                    n_count  = 32'd0;
                    n_length = 32'd0;
                    n_type   = 32'd0;
                end
            end
            PH_CRC_END: begin
                n_count = count_inc[31:0];
                if (eff_count[1:0] == 2'd3) begin
                    n_phase = PH_DONE;
                    n_count = 32'd0;
                end
            end
            default: begin
            end
        endcase

        if (n_phase == PH_DONE) begin
            op.status = pcd_pkg::ST_DONE;
        end else if (n_phase == PH_ERROR) begin
            op.status = pcd_pkg::ST_ERROR;
        end else begin
            op.status = pcd_pkg::ST_RUN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SIG;
            r_count  <= 32'd0;
            r_length <= 32'd0;
            r_type   <= 32'd0;
            r_sig_ok <= 1'b1;
        end else if (o_push) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_length <= n_length;
            r_type   <= n_type;
            r_sig_ok <= n_sig_ok;
        end
    end

    a_data_only_in_idat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && (o_op.kind == pcd_pkg::K_DATA) |-> (r_phase == PH_IDAT) && !i_restart)
        else $error("payload beat issued outside an IDAT chunk");

    a_count_below_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) || (r_phase == PH_IDAT) |-> r_count < r_length)
        else $error("chunk byte count ran past the chunk length");

endmodule

FILE: hdl/pcd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG chunk deframer op queue
// Short FIFO of ops between the front parser and the back end, so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module pcd_queue #(
    parameter int DEPTH = pcd_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pcd_pkg::t_op  i_op,
    output logic          o_full,
    output logic          o_valid,
    output pcd_pkg::t_op  o_op,
    input  logic          i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pcd_pkg::t_op     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count exceeds its depth");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("op pushed into a full queue");

endmodule

FILE: hdl/pcd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG chunk deframer back end
// Applies queued ops to the image header registers and holds the result
// beat in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module pcd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  pcd_pkg::t_op  i_q_op,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_out_byte,
    output logic          o_out_valid,
    output logic          o_stream_begin,
    output logic          o_stream_last,
    output logic          o_header_ready,
    output logic [31:0]   o_image_width,
    output logic [31:0]   o_image_height,
    output logic [7:0]    o_bit_depth,
    output logic [1:0]    o_status
);

    logic        r_valid;
    logic [31:0] r_width,  n_width;
    logic [31:0] r_height, n_height;
    logic [7:0]  r_depth,  n_depth;

    logic [7:0]  r_o_byte;
    logic        r_o_data;
    logic        r_o_begin;
    logic        r_o_last;
    logic        r_o_hdr;
    logic [31:0] r_o_width;
    logic [31:0] r_o_height;
    logic [7:0]  r_o_depth;
    logic [1:0]  r_o_status;

    logic        is_data;

    assign o_pop   = i_q_valid && (!r_valid || !i_stall);
    assign is_data = (i_q_op.kind == pcd_pkg::K_DATA);

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_depth  = r_depth;
        if (i_q_op.kind == pcd_pkg::K_WIDTH) begin
            n_width = {r_width[23:0], i_q_op.data};
        end
        if (i_q_op.kind == pcd_pkg::K_HEIGHT) begin
            n_height = {r_height[23:0], i_q_op.data};
        end
        if (i_q_op.kind == pcd_pkg::K_DEPTH) begin
            n_depth = i_q_op.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_width  <= 32'd0;
            r_height <= 32'd0;
            r_depth  <= 8'd0;
        end else begin
            if (o_pop) begin
                r_valid  <= 1'b1;
                r_width  <= n_width;
                r_height <= n_height;
                r_depth  <= n_depth;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_o_byte   <= is_data ? i_q_op.data : 8'd0;
            r_o_data   <= is_data;
            r_o_begin  <= i_q_op.begin_mark;
            r_o_last   <= i_q_op.last_mark;
            r_o_hdr    <= i_q_op.hdr_ready;
            r_o_width  <= n_width;
            r_o_height <= n_height;
            r_o_depth  <= n_depth;
            r_o_status <= i_q_op.status;
        end
    end

    assign o_valid        = r_valid;
    assign o_out_byte     = r_o_byte;
    assign o_out_valid    = r_o_data;
    assign o_stream_begin = r_o_begin;
    assign o_stream_last  = r_o_last;
    assign o_header_ready = r_o_hdr;
    assign o_image_width  = r_o_width;
    assign o_image_height = r_o_height;
    assign o_bit_depth    = r_o_depth;
    assign o_status       = r_o_status;

    a_marks_need_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && (i_q_op.begin_mark || i_q_op.last_mark) |=> o_out_valid)
        else $error("stream mark carried on a beat without payload");

endmodule
